/* rtl/core/lsrg_pkg.sv */
// lsrg_pkg: shared types and constants of the lagged subtractive generator
// no dependencies; imported by lsrg_ctrl, lsrg_dp and the top level
package lsrg_pkg;

    localparam int LAG_DEPTH = 17;

    typedef logic [4:0]  ptr_t;
    typedef logic [14:0] word_t;

    localparam ptr_t        LAG_TOP     = 5'd16;
    localparam ptr_t        SHORT_START = 5'd4;
    localparam ptr_t        LAG_SPAN    = 5'd12;
    localparam ptr_t        LAG_SHORT   = 5'd5;
    localparam logic [13:0] SEED_MULT   = 14'd9069;
    localparam word_t       SEED_MAX    = 15'd32767;

    localparam word_t INIT_TABLE [LAG_DEPTH] = '{
        15'd30788, 15'd23052, 15'd2053,  15'd19346, 15'd10646, 15'd19427,
        15'd23975, 15'd19049, 15'd10949, 15'd19693, 15'd29746, 15'd26748,
        15'd2796,  15'd23890, 15'd29168, 15'd31924, 15'd16499
    };

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SEED = 4'b0010,
        ST_READ = 4'b0100,
        ST_CALC = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic seed_step;
        logic read;
        logic calc;
    } cmd_t;

    typedef struct packed {
        logic seed_nz;
        logic seed_last;
        logic out_free;
    } status_t;

endpackage

/* rtl/core/lagged_subtractive_random_generator.sv */
// lagged_subtractive_random_generator: subtractive lag 17/5 generator, modulus 32767
// depends on lsrg_pkg, lsrg_ctrl and lsrg_dp
//
//  channel   direction  ports                       beat
//  s_        in         s_valid s_ready s_seed      one draw request (nonzero seed reseeds)
//  m_        out        m_valid m_ready m_value     one drawn value 0..32767
//
// a plain draw steps through accept, registered two-port table read, subtract and write-back
// a nonzero seed adds a reseed pass over all 17 table words, one per cycle through the single 15x14 multiplier
// reset restores the power-on table at once through per-word valid bits, no clearing pass
// a stalled result register holds the next draw in its subtract step until m_ready
module lagged_subtractive_random_generator
    import lsrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_seed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_value
);

    cmd_t    cmd;
    status_t status;

    lsrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lsrg_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_seed  (s_seed),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_value (m_value),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

/* rtl/core/lsrg_ctrl.sv */
// lsrg_ctrl: sequencer for reseed, table read and subtract steps
// depends on lsrg_pkg
module lsrg_ctrl
    import lsrg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_seed = status.seed_nz;
                    state_next    = status.seed_nz ? ST_SEED : ST_READ;
                end
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (status.seed_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (status.out_free) begin
                    cmd.calc   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_reseed_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && status.seed_nz) |=> (state_reg == ST_SEED))
        else $error("nonzero seed did not start the reseed");

    a_seed_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED && status.seed_last) |=> (state_reg == ST_READ))
        else $error("reseed did not hand over to the table read");

endmodule

/* rtl/core/lsrg_dp.sv */
// lsrg_dp: lag table, pointers, seed multiplier and result register
// depends on lsrg_pkg; driven by lsrg_ctrl commands
module lsrg_dp
    import lsrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_seed,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [14:0] m_value,
    input  cmd_t        cmd,
    output status_t     status
);

    word_t              mem [LAG_DEPTH];
    logic [LAG_DEPTH-1:0] valid_reg, valid_next;

    ptr_t  sp_reg, sp_next;
    ptr_t  lp_reg, lp_next;
    ptr_t  cnt_reg, cnt_next;
    word_t x_reg, x_next;
    word_t rd_a_reg, rd_b_reg;
    word_t value_reg;
    logic  m_valid_reg, m_valid_next;

    logic [31:0] seed_mag;
    word_t       seed_sat;
    logic [28:0] seed_prod;
    word_t       seed_word;
    logic [15:0] diff;
    word_t       k_word;
    logic        wr_en;
    ptr_t        wr_addr;
    word_t       wr_data;

    // seed magnitude, saturated and forced odd
    assign seed_mag  = s_seed[31] ? (~s_seed + 32'd1) : s_seed;
    assign seed_sat  = (seed_mag > {17'd0, SEED_MAX}) ? SEED_MAX : seed_mag[14:0];

    assign seed_prod = {14'd0, x_reg} * {15'd0, SEED_MULT};
    assign seed_word = seed_prod[14:0];

    // a - b, with 32767 added back on borrow (mod 32768 that is one less)
    assign diff   = {1'b0, rd_a_reg} - {1'b0, rd_b_reg};
    assign k_word = diff[14:0] - {14'd0, diff[15]};

    assign status.seed_nz   = (s_seed != 32'd0);
    assign status.seed_last = (cnt_reg == LAG_TOP);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en   = cmd.seed_step || cmd.calc;
        wr_addr = cmd.seed_step ? cnt_reg : lp_reg;
        wr_data = cmd.seed_step ? seed_word : k_word;
    end

    always_comb begin
        sp_next      = sp_reg;
        lp_next      = lp_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load_seed) begin
            x_next   = seed_sat[0] ? seed_sat : seed_sat - 15'd1;
            cnt_next = '0;
        end
        if (cmd.seed_step) begin
            x_next   = seed_word;
            cnt_next = cnt_reg + 5'd1;
            if (status.seed_last) begin
                cnt_next = '0;
                sp_next  = SHORT_START;
                lp_next  = LAG_TOP;
            end
        end
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
        if (cmd.calc) begin
            sp_next      = (sp_reg == '0) ? LAG_TOP : sp_reg - 5'd1;
            lp_next      = (lp_reg == '0) ? LAG_TOP : lp_reg - 5'd1;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= SHORT_START;
            lp_reg      <= LAG_TOP;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sp_reg      <= sp_next;
            lp_reg      <= lp_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        if (cmd.calc) begin
            value_reg <= k_word;
        end
    end

    // lag table; entries not yet written read as the power-on table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_a_reg <= valid_reg[sp_reg] ? mem[sp_reg] : INIT_TABLE[sp_reg];
            rd_b_reg <= valid_reg[lp_reg] ? mem[lp_reg] : INIT_TABLE[lp_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = value_reg;

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg <= LAG_TOP) && (lp_reg <= LAG_TOP) && (cnt_reg <= LAG_TOP))
        else $error("pointer or seed counter out of table range");

    a_ptr_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (lp_reg == sp_reg + LAG_SPAN) || (sp_reg == lp_reg + LAG_SHORT))
        else $error("short and long pointers lost their lag spacing");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc |=> m_valid_reg)
        else $error("draw finished without raising the result");

endmodule
